### hw/rtl/rbsi_pkg.sv
package rbsi_pkg;

    // default number formats: signed Q16.16
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // box face codes
    typedef logic [2:0] face_t;
    localparam face_t FACE_NEG_X = 3'd0;
    localparam face_t FACE_NEG_Y = 3'd1;
    localparam face_t FACE_NEG_Z = 3'd2;
    localparam face_t FACE_POS_X = 3'd3;
    localparam face_t FACE_POS_Y = 3'd4;
    localparam face_t FACE_POS_Z = 3'd5;

endpackage

### hw/rtl/ray_box_slab_intersect_top.sv
// Ray versus axis-aligned box slab test in signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction bits). Each transfer on the slave side carries a ray origin and direction and the
// box corners; each transfer on the master side returns one result: the hit flag on tuser and
// the entry distance, the hit point and the nearest face on tdata (all zero on a miss). The
// pipeline takes a new transfer every cycle and gives one result every cycle while the master
// side does not stall; the default format is Q16.16. The six slab dividers retire one quotient
// bit per stage over WORD_BITS + FRAC_BITS + 1 stages. A stall on the master side holds the
// whole pipeline in place.
module ray_box_slab_intersect_top
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int IN_W  = ((12 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((4 * WORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, box_min_x/y/z, box_max_x/y/z, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit_distance, hit_point_x, hit_point_y, hit_point_z, face_code, zero pad
    output logic [OUT_W-1:0] m_tdata,
    // hit
    output logic [0:0]       m_tuser
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int W2  = 2 * W;
    localparam int NB  = W + 1 + F;   // dividend / quotient bits
    localparam int RW  = W + 1;       // remainder bits
    localparam int L   = W / 2;       // low half for partial products
    localparam int H   = W - L;
    localparam int PAD = OUT_W - (4 * W + 3);

    localparam logic [NB-1:0] TLIM_Q = NB'(1) << (W - 1);
    localparam logic [NB-1:0] TMAX_Q = TLIM_Q - NB'(1);
    localparam logic [W-1:0]  MAXW   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINW   = {1'b1, {(W-1){1'b0}}};
    localparam logic [W2-1:0] PCL    = W2'(1) << W;

    typedef struct packed {
        logic [2:0][W-1:0] o;
        logic [2:0][W-1:0] d;
        logic [2:0][W-1:0] mn;
        logic [2:0][W-1:0] mx;
        logic [5:0]        neg;    // quotient sign per divider
        logic [2:0]        dz;     // zero direction component
        logic              miss;   // origin outside a slab of a zero-direction axis
    } side_t;

    // whole pipeline advances unless the output holds a result not yet taken
    logic out_vld_reg;
    logic en;
    assign en = !out_vld_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 0: input register ----------------
    logic  in_vld_reg;
    side_t in_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                in_side_reg.o[k]  <= s_tdata[k * W +: W];
                in_side_reg.d[k]  <= s_tdata[(3 + k) * W +: W];
                in_side_reg.mn[k] <= s_tdata[(6 + k) * W +: W];
                in_side_reg.mx[k] <= s_tdata[(9 + k) * W +: W];
            end
            in_side_reg.neg  <= '0;
            in_side_reg.dz   <= '0;
            in_side_reg.miss <= 1'b0;
        end
    end

    // ---------------- divider pipeline arrays ----------------
    logic          div_vld_reg  [0:NB];
    side_t         div_side_reg [0:NB];
    logic [W-1:0]  div_ud_reg   [0:NB][3];
    logic [RW-1:0] div_rem_reg  [0:NB][6];
    logic [NB-1:0] div_dq_reg   [0:NB][6];

    // ---------------- stage 1: numerators, divisors, zero-direction checks ----------------
    side_t         prep_side_next;
    logic [W-1:0]  prep_ud_next [3];
    logic [NB-1:0] prep_dq_next [6];

    always_comb begin
        logic [W:0]   na;
        logic [W:0]   nb;
        logic         dneg;
        logic [W-1:0] lo;
        logic [W-1:0] hi;
        prep_side_next      = in_side_reg;
        prep_side_next.miss = 1'b0;
        for (int k = 0; k < 3; k++) begin
            na   = {in_side_reg.mn[k][W-1], in_side_reg.mn[k]}
                 - {in_side_reg.o[k][W-1], in_side_reg.o[k]};
            nb   = {in_side_reg.mx[k][W-1], in_side_reg.mx[k]}
                 - {in_side_reg.o[k][W-1], in_side_reg.o[k]};
            dneg = in_side_reg.d[k][W-1];
            prep_ud_next[k] = dneg ? (~in_side_reg.d[k] + 1'b1) : in_side_reg.d[k];
            prep_dq_next[2*k]     = {(na[W] ? (~na + 1'b1) : na), {F{1'b0}}};
            prep_dq_next[2*k + 1] = {(nb[W] ? (~nb + 1'b1) : nb), {F{1'b0}}};
            prep_side_next.neg[2*k]     = na[W] ^ dneg;
            prep_side_next.neg[2*k + 1] = nb[W] ^ dneg;
            prep_side_next.dz[k] = (in_side_reg.d[k] == '0);
            // slab bounds in either corner order
            if ($signed(in_side_reg.mn[k]) < $signed(in_side_reg.mx[k])) begin
                lo = in_side_reg.mn[k];
                hi = in_side_reg.mx[k];
            end else begin
                lo = in_side_reg.mx[k];
                hi = in_side_reg.mn[k];
            end
            if (prep_side_next.dz[k] && ($signed(in_side_reg.o[k]) < $signed(lo)
                    || $signed(in_side_reg.o[k]) > $signed(hi))) begin
                prep_side_next.miss = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_vld_reg[0] <= 1'b0;
        end else if (en) begin
            div_vld_reg[0] <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_side_reg[0] <= prep_side_next;
            for (int k = 0; k < 3; k++) begin
                div_ud_reg[0][k] <= prep_ud_next[k];
            end
            for (int i = 0; i < 6; i++) begin
                div_rem_reg[0][i] <= '0;
                div_dq_reg[0][i]  <= prep_dq_next[i];
            end
        end
    end

    // ---------------- restoring division, one quotient bit per stage ----------------
    // dividend bits shift out of the top of dq while quotient bits shift in at the bottom
    for (genvar j = 0; j < NB; j++) begin : g_div
        logic [RW-1:0] rem_next [6];
        logic [NB-1:0] dq_next  [6];

        always_comb begin
            logic [RW-1:0] sh;
            logic          ge;
            for (int i = 0; i < 6; i++) begin
                sh = {div_rem_reg[j][i][RW-2:0], div_dq_reg[j][i][NB-1]};
                ge = (sh >= {1'b0, div_ud_reg[j][i >> 1]});
                rem_next[i] = ge ? (sh - {1'b0, div_ud_reg[j][i >> 1]}) : sh;
                dq_next[i]  = {div_dq_reg[j][i][NB-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                div_vld_reg[j+1] <= div_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_side_reg[j+1] <= div_side_reg[j];
                for (int k = 0; k < 3; k++) begin
                    div_ud_reg[j+1][k] <= div_ud_reg[j][k];
                end
                for (int i = 0; i < 6; i++) begin
                    div_rem_reg[j+1][i] <= rem_next[i];
                    div_dq_reg[j+1][i]  <= dq_next[i];
                end
            end
        end
    end

    // ---------------- stage A: saturate and sign the slab distances ----------------
    logic         a_vld_reg;
    side_t        a_side_reg;
    logic [W-1:0] a_t_reg  [6];
    logic [W-1:0] a_t_next [6];

    always_comb begin
        logic [NB-1:0] qs;
        for (int i = 0; i < 6; i++) begin
            qs = (div_dq_reg[NB][i] > TLIM_Q) ? TLIM_Q : div_dq_reg[NB][i];
            if (div_side_reg[NB].neg[i]) begin
                a_t_next[i] = ~qs[W-1:0] + 1'b1;
            end else begin
                a_t_next[i] = (qs > TMAX_Q) ? MAXW : qs[W-1:0];
            end
        end
    end

    // ---------------- stage B: order the two planes per axis ----------------
    logic         b_vld_reg;
    side_t        b_side_reg;
    logic [W-1:0] b_lo_reg [3];
    logic [W-1:0] b_hi_reg [3];

    // ---------------- stage C: entry / exit distances and hit decision ----------------
    logic         c_vld_reg;
    side_t        c_side_reg;
    logic [W-1:0] c_t0_reg;
    logic         c_hit_reg;
    logic [W-1:0] c_t0_next;
    logic         c_hit_next;

    always_comb begin
        logic [W-1:0] t1;
        c_t0_next = MINW;
        t1        = MAXW;
        for (int k = 0; k < 3; k++) begin
            if (!b_side_reg.dz[k]) begin
                if ($signed(b_lo_reg[k]) > $signed(c_t0_next)) c_t0_next = b_lo_reg[k];
                if ($signed(b_hi_reg[k]) < $signed(t1))        t1 = b_hi_reg[k];
            end
        end
        c_hit_next = !b_side_reg.miss && ($signed(c_t0_next) <= $signed(t1))
                     && ($signed(t1) > $signed(W'(0)));
    end

    // ---------------- stage D: partial products of |dir| * |t0| ----------------
    logic         d_vld_reg;
    side_t        d_side_reg;
    logic [W-1:0] d_t0_reg;
    logic         d_hit_reg;
    logic [2:0]   d_neg_reg;
    logic [2*L-1:0] d_pp00_reg [3];
    logic [L+H-1:0] d_pp01_reg [3];
    logic [L+H-1:0] d_pp10_reg [3];
    logic [2*H-1:0] d_pp11_reg [3];
    logic [2*L-1:0] d_pp00_next [3];
    logic [L+H-1:0] d_pp01_next [3];
    logic [L+H-1:0] d_pp10_next [3];
    logic [2*H-1:0] d_pp11_next [3];

    always_comb begin
        logic [W-1:0] ua;
        logic [W-1:0] ub;
        ub = c_t0_reg[W-1] ? (~c_t0_reg + 1'b1) : c_t0_reg;
        for (int k = 0; k < 3; k++) begin
            ua = c_side_reg.d[k][W-1] ? (~c_side_reg.d[k] + 1'b1) : c_side_reg.d[k];
            d_pp00_next[k] = ua[L-1:0] * ub[L-1:0];
            d_pp01_next[k] = ua[L-1:0] * ub[W-1:L];
            d_pp10_next[k] = ua[W-1:L] * ub[L-1:0];
            d_pp11_next[k] = ua[W-1:L] * ub[W-1:L];
        end
    end

    // ---------------- stage E: full product ----------------
    logic          e_vld_reg;
    side_t         e_side_reg;
    logic [W-1:0]  e_t0_reg;
    logic          e_hit_reg;
    logic [2:0]    e_neg_reg;
    logic [W2-1:0] e_prod_reg [3];

    // ---------------- stage F: scale, clamp, add origin, saturate ----------------
    logic         f_vld_reg;
    side_t        f_side_reg;
    logic [W-1:0] f_t0_reg;
    logic         f_hit_reg;
    logic [W-1:0] f_p_reg  [3];
    logic [W-1:0] f_p_next [3];

    always_comb begin
        logic [W2-1:0] m;
        logic [W:0]    mc;
        logic [W+1:0]  sum;
        for (int k = 0; k < 3; k++) begin
            m   = e_prod_reg[k] >> F;
            mc  = (m > PCL) ? PCL[W:0] : m[W:0];
            if (e_neg_reg[k]) begin
                sum = {{2{e_side_reg.o[k][W-1]}}, e_side_reg.o[k]} - {1'b0, mc};
            end else begin
                sum = {{2{e_side_reg.o[k][W-1]}}, e_side_reg.o[k]} + {1'b0, mc};
            end
            if ($signed(sum) > $signed({2'b00, MAXW})) begin
                f_p_next[k] = MAXW;
            end else if ($signed(sum) < $signed({2'b11, MINW})) begin
                f_p_next[k] = MINW;
            end else begin
                f_p_next[k] = sum[W-1:0];
            end
        end
    end

    // ---------------- stage G: distance to each face plane ----------------
    logic         g_vld_reg;
    logic [W-1:0] g_t0_reg;
    logic         g_hit_reg;
    logic [W-1:0] g_p_reg    [3];
    logic [W:0]   g_dist_reg [6];
    logic [W:0]   g_dist_next [6];

    always_comb begin
        logic [W:0] dmn;
        logic [W:0] dmx;
        for (int k = 0; k < 3; k++) begin
            dmn = {f_p_reg[k][W-1], f_p_reg[k]} - {f_side_reg.mn[k][W-1], f_side_reg.mn[k]};
            dmx = {f_p_reg[k][W-1], f_p_reg[k]} - {f_side_reg.mx[k][W-1], f_side_reg.mx[k]};
            g_dist_next[k]     = dmn[W] ? (~dmn + 1'b1) : dmn;
            g_dist_next[3 + k] = dmx[W] ? (~dmx + 1'b1) : dmx;
        end
    end

    // ---------------- stage H: nearest face within min faces and within max faces ----------------
    logic         h_vld_reg;
    logic [W-1:0] h_t0_reg;
    logic         h_hit_reg;
    logic [W-1:0] h_p_reg [3];
    logic [W:0]   h_best_a_reg;
    logic [W:0]   h_best_b_reg;
    face_t        h_face_a_reg;
    face_t        h_face_b_reg;
    logic [W:0]   h_best_a_next;
    logic [W:0]   h_best_b_next;
    face_t        h_face_a_next;
    face_t        h_face_b_next;

    // earlier face keeps a tie
    always_comb begin
        h_best_a_next = g_dist_reg[0];
        h_face_a_next = FACE_NEG_X;
        if (g_dist_reg[1] < h_best_a_next) begin
            h_best_a_next = g_dist_reg[1];
            h_face_a_next = FACE_NEG_Y;
        end
        if (g_dist_reg[2] < h_best_a_next) begin
            h_best_a_next = g_dist_reg[2];
            h_face_a_next = FACE_NEG_Z;
        end
        h_best_b_next = g_dist_reg[3];
        h_face_b_next = FACE_POS_X;
        if (g_dist_reg[4] < h_best_b_next) begin
            h_best_b_next = g_dist_reg[4];
            h_face_b_next = FACE_POS_Y;
        end
        if (g_dist_reg[5] < h_best_b_next) begin
            h_best_b_next = g_dist_reg[5];
            h_face_b_next = FACE_POS_Z;
        end
    end

    // ---------------- output register ----------------
    logic         out_hit_reg;
    logic [W-1:0] out_t0_reg;
    logic [W-1:0] out_p_reg [3];
    face_t        out_face_reg;
    face_t        out_face_next;

    assign out_face_next = (h_best_b_reg < h_best_a_reg) ? h_face_b_reg : h_face_a_reg;

    // valid chain for the back half
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg   <= div_vld_reg[NB];
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            out_vld_reg <= h_vld_reg;
        end
    end

    // payload for the back half
    always_ff @(posedge aclk) begin
        if (en) begin
            // A
            a_side_reg <= div_side_reg[NB];
            for (int i = 0; i < 6; i++) a_t_reg[i] <= a_t_next[i];
            // B
            b_side_reg <= a_side_reg;
            for (int k = 0; k < 3; k++) begin
                if ($signed(a_t_reg[2*k]) < $signed(a_t_reg[2*k + 1])) begin
                    b_lo_reg[k] <= a_t_reg[2*k];
                    b_hi_reg[k] <= a_t_reg[2*k + 1];
                end else begin
                    b_lo_reg[k] <= a_t_reg[2*k + 1];
                    b_hi_reg[k] <= a_t_reg[2*k];
                end
            end
            // C
            c_side_reg <= b_side_reg;
            c_t0_reg   <= c_t0_next;
            c_hit_reg  <= c_hit_next;
            // D
            d_side_reg <= c_side_reg;
            d_t0_reg   <= c_t0_reg;
            d_hit_reg  <= c_hit_reg;
            for (int k = 0; k < 3; k++) begin
                d_neg_reg[k]  <= c_side_reg.d[k][W-1] ^ c_t0_reg[W-1];
                d_pp00_reg[k] <= d_pp00_next[k];
                d_pp01_reg[k] <= d_pp01_next[k];
                d_pp10_reg[k] <= d_pp10_next[k];
                d_pp11_reg[k] <= d_pp11_next[k];
            end
            // E
            e_side_reg <= d_side_reg;
            e_t0_reg   <= d_t0_reg;
            e_hit_reg  <= d_hit_reg;
            e_neg_reg  <= d_neg_reg;
            for (int k = 0; k < 3; k++) begin
                e_prod_reg[k] <= W2'(d_pp00_reg[k]) + (W2'(d_pp01_reg[k]) << L)
                               + (W2'(d_pp10_reg[k]) << L) + (W2'(d_pp11_reg[k]) << (2 * L));
            end
            // F
            f_side_reg <= e_side_reg;
            f_t0_reg   <= e_t0_reg;
            f_hit_reg  <= e_hit_reg;
            for (int k = 0; k < 3; k++) f_p_reg[k] <= f_p_next[k];
            // G
            g_t0_reg  <= f_t0_reg;
            g_hit_reg <= f_hit_reg;
            for (int k = 0; k < 3; k++) g_p_reg[k] <= f_p_reg[k];
            for (int i = 0; i < 6; i++) g_dist_reg[i] <= g_dist_next[i];
            // H
            h_t0_reg     <= g_t0_reg;
            h_hit_reg    <= g_hit_reg;
            for (int k = 0; k < 3; k++) h_p_reg[k] <= g_p_reg[k];
            h_best_a_reg <= h_best_a_next;
            h_best_b_reg <= h_best_b_next;
            h_face_a_reg <= h_face_a_next;
            h_face_b_reg <= h_face_b_next;
            // output: a miss returns all zeros
            out_hit_reg  <= h_hit_reg;
            out_t0_reg   <= h_hit_reg ? h_t0_reg : '0;
            for (int k = 0; k < 3; k++) out_p_reg[k] <= h_hit_reg ? h_p_reg[k] : '0;
            out_face_reg <= h_hit_reg ? out_face_next : FACE_NEG_X;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tuser[0] = out_hit_reg;
    assign m_tdata    = {{PAD{1'b0}}, out_face_reg, out_p_reg[2], out_p_reg[1], out_p_reg[0],
                         out_t0_reg};

endmodule
